/* rtl/display_link_frame_responder_core_defines.svh */
// ----------------------------------------------------------------------------
// display link frame responder assertion macros
// immediate-free property wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef DISPLAY_LINK_FRAME_RESPONDER_CORE_DEFINES_SVH
`define DISPLAY_LINK_FRAME_RESPONDER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define DLFR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dlfr property failed");
`define DLFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dlfr property failed");
`else
`define DLFR_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DLFR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/dlfr_pkg.sv */
// ----------------------------------------------------------------------------
// dlfr_pkg
// shared types, constants and reply byte builder of the frame responder
// ----------------------------------------------------------------------------
package dlfr_pkg;

   localparam int WIN_LEN     = 20;
   localparam int REPLY_LEN   = 14;
   localparam int CNT_W       = $clog2(WIN_LEN);
   localparam int IDX_W       = $clog2(REPLY_LEN + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] HDR_B0 = 8'h01;
   localparam logic [7:0] HDR_B1 = 8'h14;
   localparam logic [7:0] HDR_B2 = 8'h01;
   localparam logic [7:0] MAGIC_B0 = 8'h02;
   localparam logic [7:0] MAGIC_B1 = 8'h0E;
   localparam logic [7:0] MAGIC_B2 = 8'h01;

   // error flag bit positions
   localparam int ERR_E06 = 0;
   localparam int ERR_E07 = 1;
   localparam int ERR_E09 = 2;
   localparam int ERR_E11 = 3;

   typedef enum logic [1:0] {
      CMD_BYTE  = 2'd0,
      CMD_TELEM = 2'd1,
      CMD_ERROR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      EC_CLEAR = 3'd0,
      EC_E06   = 3'd1,
      EC_E07   = 3'd2,
      EC_E09   = 3'd3,
      EC_E11   = 3'd4
   } err_code_type;

   typedef enum logic [1:0] {
      KIND_REPLY    = 2'd0,
      KIND_REPORT   = 2'd1,
      KIND_CSUM_ERR = 2'd2
   } kind_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  rx_byte;
      logic [15:0] motor_current;
      logic [15:0] wheel_period;
      logic        brake_on;
      logic        push_on;
      logic [2:0]  error_code;
   } req_type;

   // one classified frame, with the telemetry snapshot taken when it closed
   typedef struct packed {
      logic        good;
      logic [15:0] current;
      logic [15:0] period;
      logic        brake;
      logic        push;
      logic [3:0]  err;
      logic [7:0]  assist;
      logic        assist_chg;
      logic        head;
      logic        head_chg;
      logic        push_req;
      logic [7:0]  attack;
      logic [7:0]  sens;
      logic        pas_chg;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  tx_byte;
      logic        last;
      logic [7:0]  assist_step;
      logic        assist_changed;
      logic        headlight;
      logic        headlight_changed;
      logic        push_request;
      logic [7:0]  pedal_attack;
      logic [7:0]  pedal_sense;
      logic        pas_changed;
   } rsp_type;

   function automatic logic [7:0] reply_byte(job_type j, logic [IDX_W-1:0] idx);
      logic [7:0] f3;
      logic [7:0] f4;
      logic [7:0] x;
      logic [7:0] b;
      f3 = {3'b000, j.err[ERR_E09], j.err[ERR_E06], j.push, 1'b0, j.err[ERR_E07]};
      f4 = {2'b00, j.brake, j.err[ERR_E11], 4'b0000};
      x  = MAGIC_B0 ^ MAGIC_B1 ^ MAGIC_B2 ^ f3 ^ f4 ^ j.current[15:8] ^ j.current[7:0]
           ^ j.period[15:8] ^ j.period[7:0];
      case (idx)
         IDX_W'(0):  b = MAGIC_B0;
         IDX_W'(1):  b = MAGIC_B1;
         IDX_W'(2):  b = MAGIC_B2;
         IDX_W'(3):  b = f3;
         IDX_W'(4):  b = f4;
         IDX_W'(6):  b = j.current[15:8];
         IDX_W'(7):  b = j.current[7:0];
         IDX_W'(8):  b = j.period[15:8];
         IDX_W'(9):  b = j.period[7:0];
         IDX_W'(REPLY_LEN - 1): b = x;
         default:    b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

/* rtl/dlfr_front.sv */
// ----------------------------------------------------------------------------
// dlfr_front
// accepts requests, keeps the receive window and telemetry, classifies frames
// ----------------------------------------------------------------------------
module dlfr_front
   import dlfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   output logic    job_push,
   output job_type job
);

   logic [7:0]       window_ff [WIN_LEN];
   logic [7:0]       window_in [WIN_LEN];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      current_ff, current_in;
   logic [15:0]      period_ff, period_in;
   logic             brake_ff, brake_in;
   logic             push_ff, push_in;
   logic [3:0]       err_ff, err_in;
   logic [7:0]       prev_assist_ff, prev_assist_in;
   logic             prev_head_ff, prev_head_in;
   logic [7:0]       prev_attack_ff, prev_attack_in;
   logic [7:0]       prev_sens_ff, prev_sens_in;
   logic [7:0]       csum;
   logic             hdr_ok;
   logic             closing;

   always_comb begin
      csum = 8'h00;
      for (int i = 0; i < WIN_LEN - 1; i++) begin
         csum = csum ^ window_ff[i];
      end
   end

   assign hdr_ok  = (window_ff[0] == HDR_B0) && (window_ff[1] == HDR_B1) &&
                    (window_ff[2] == HDR_B2);
   assign closing = (count_ff == CNT_W'(WIN_LEN - 1));

   always_comb begin
      job.good       = (csum == req.rx_byte);
      job.current    = current_ff;
      job.period     = period_ff;
      job.brake      = brake_ff;
      job.push       = push_ff;
      job.err        = err_ff;
      job.assist     = window_ff[4];
      job.assist_chg = (window_ff[4] != prev_assist_ff);
      job.head       = window_ff[5][5];
      job.head_chg   = (window_ff[5][5] != prev_head_ff);
      job.push_req   = window_ff[5][1];
      job.attack     = window_ff[10];
      job.sens       = window_ff[9];
      job.pas_chg    = (window_ff[10] != prev_attack_ff) || (window_ff[9] != prev_sens_ff);
   end

   always_comb begin
      window_in      = window_ff;
      count_in       = count_ff;
      current_in     = current_ff;
      period_in      = period_ff;
      brake_in       = brake_ff;
      push_in        = push_ff;
      err_in         = err_ff;
      prev_assist_in = prev_assist_ff;
      prev_head_in   = prev_head_ff;
      prev_attack_in = prev_attack_ff;
      prev_sens_in   = prev_sens_ff;
      job_push       = 1'b0;
      if (accept) begin
         case (cmd_type'(req.cmd))
            CMD_TELEM: begin
               current_in = req.motor_current;
               period_in  = req.wheel_period;
               brake_in   = req.brake_on;
               push_in    = req.push_on;
            end
            CMD_ERROR: begin
               case (err_code_type'(req.error_code))
                  EC_E06:  err_in = err_ff | (4'b0001 << ERR_E06);
                  EC_E07:  err_in = err_ff | (4'b0001 << ERR_E07);
                  EC_E09:  err_in = err_ff | (4'b0001 << ERR_E09);
                  EC_E11:  err_in = err_ff | (4'b0001 << ERR_E11);
                  default: err_in = 4'b0000;
               endcase
            end
            CMD_BYTE: begin
               if (!closing) begin
                  window_in[count_ff] = req.rx_byte;
                  count_in            = count_ff + CNT_W'(1);
               end else if (hdr_ok) begin
                  count_in = '0;
                  job_push = 1'b1;
                  if (job.good) begin
                     prev_assist_in = job.assist;
                     prev_head_in   = job.head;
                     prev_attack_in = job.attack;
                     prev_sens_in   = job.sens;
                  end
               end else begin
                  // no frame start: slide the window by one byte
                  for (int i = 0; i < WIN_LEN - 2; i++) begin
                     window_in[i] = window_ff[i + 1];
                  end
                  window_in[WIN_LEN - 2] = req.rx_byte;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      if (reset) begin
         count_ff       <= '0;
         current_ff     <= '0;
         period_ff      <= '0;
         brake_ff       <= 1'b0;
         push_ff        <= 1'b0;
         err_ff         <= '0;
         prev_assist_ff <= '0;
         prev_head_ff   <= 1'b0;
         prev_attack_ff <= '0;
         prev_sens_ff   <= '0;
      end else begin
         count_ff       <= count_in;
         current_ff     <= current_in;
         period_ff      <= period_in;
         brake_ff       <= brake_in;
         push_ff        <= push_in;
         err_ff         <= err_in;
         prev_assist_ff <= prev_assist_in;
         prev_head_ff   <= prev_head_in;
         prev_attack_ff <= prev_attack_in;
         prev_sens_ff   <= prev_sens_in;
      end
   end

endmodule

/* rtl/dlfr_queue.sv */
// ----------------------------------------------------------------------------
// dlfr_queue
// short job queue between the classifier and the reply sequencer
// ----------------------------------------------------------------------------
module dlfr_queue
   import dlfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  job_type    wdata,
   input  logic       pop,
   output job_type    rdata,
   output q_stat_type stat
);

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign rdata      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/dlfr_back.sv */
// ----------------------------------------------------------------------------
// dlfr_back
// walks each queued job through its reply bytes and report, or one checksum error, into the output register
// ----------------------------------------------------------------------------
module dlfr_back
   import dlfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  q_stat_type q_stat,
   input  job_type    q_data,
   output logic       q_pop,
   input  logic       rsp_take,
   output logic       rsp_valid,
   output rsp_type    rsp
);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   rsp_type          rsp_ff, rsp_in;
   rsp_type          res;
   logic             load;

   assign load = !q_stat.empty && (!valid_ff || rsp_take);

   always_comb begin
      res = '0;
      if (!q_data.good) begin
         res.kind = KIND_CSUM_ERR;
         res.last = 1'b1;
      end else if (idx_ff == IDX_W'(REPLY_LEN)) begin
         res.kind              = KIND_REPORT;
         res.last              = 1'b1;
         res.assist_step       = q_data.assist;
         res.assist_changed    = q_data.assist_chg;
         res.headlight         = q_data.head;
         res.headlight_changed = q_data.head_chg;
         res.push_request      = q_data.push_req;
         res.pedal_attack      = q_data.attack;
         res.pedal_sense       = q_data.sens;
         res.pas_changed       = q_data.pas_chg;
      end else begin
         res.kind    = KIND_REPLY;
         res.tx_byte = reply_byte(q_data, idx_ff);
      end
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      q_pop    = 1'b0;
      if (rsp_take) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         rsp_in   = res;
         if (res.last) begin
            q_pop  = 1'b1;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

endmodule

/* rtl/display_link_frame_responder_core.sv */
// ----------------------------------------------------------------------------
// display_link_frame_responder_core
// display link frame checker and reply generator
// ----------------------------------------------------------------------------
// Requests enter through a queue-style port: a request is taken on a clock edge
// with push high and full low. req_cmd selects a received byte, a telemetry
// update or an error code update. Results leave through a second queue-style
// port: while empty is low the oldest result sits on the rsp_ ports, and it is
// taken on an edge with pop high.
// A byte that closes a 20-byte window starting 01 14 01 yields 15 results (14
// reply bytes, then the frame report) or one checksum error result. The first
// result passes the frame queue and the output register; the rest follow one
// per cycle while pop is high, from the reply sequencer, one frame at a time.
// Requests are taken one per cycle while full is low; full rises only when the
// two-entry frame queue between the classifier and the sequencer is full; at
// the link's pace it is not, since 20 bytes make a frame of at most 15 results.
// Stalling pop holds the current result; the queue then absorbs frames.
// Synchronous reset empties window, queue and output and clears telemetry,
// error flags and the last-frame settings.
// ----------------------------------------------------------------------------
`include "display_link_frame_responder_core_defines.svh"

module display_link_frame_responder_core
   import dlfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_rx_byte,
   input  logic [15:0] req_motor_current,
   input  logic [15:0] req_wheel_period,
   input  logic        req_brake_on,
   input  logic        req_push_on,
   input  logic [2:0]  req_error_code,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last,
   output logic [7:0]  rsp_assist_step,
   output logic        rsp_assist_changed,
   output logic        rsp_headlight,
   output logic        rsp_headlight_changed,
   output logic        rsp_push_request,
   output logic [7:0]  rsp_pedal_attack,
   output logic [7:0]  rsp_pedal_sense,
   output logic        rsp_pas_changed
);

   req_type    req;
   job_type    front_job, q_data;
   logic       front_push, q_pop;
   q_stat_type q_stat;
   rsp_type    rsp;
   logic       rsp_valid;
   logic       accept, take;

   assign full   = q_stat.full;
   assign accept = push && !full;
   assign empty  = !rsp_valid;
   assign take   = pop && rsp_valid;

   assign req.cmd           = req_cmd;
   assign req.rx_byte       = req_rx_byte;
   assign req.motor_current = req_motor_current;
   assign req.wheel_period  = req_wheel_period;
   assign req.brake_on      = req_brake_on;
   assign req.push_on       = req_push_on;
   assign req.error_code    = req_error_code;

   dlfr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req),
      .job_push (front_push),
      .job      (front_job)
   );

   dlfr_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (front_push),
      .wdata (front_job),
      .pop   (q_pop),
      .rdata (q_data),
      .stat  (q_stat)
   );

   dlfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_take  (take),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_kind              = rsp.kind;
   assign rsp_tx_byte           = rsp.tx_byte;
   assign rsp_last              = rsp.last;
   assign rsp_assist_step       = rsp.assist_step;
   assign rsp_assist_changed    = rsp.assist_changed;
   assign rsp_headlight         = rsp.headlight;
   assign rsp_headlight_changed = rsp.headlight_changed;
   assign rsp_push_request      = rsp.push_request;
   assign rsp_pedal_attack      = rsp.pedal_attack;
   assign rsp_pedal_sense       = rsp.pedal_sense;
   assign rsp_pas_changed       = rsp.pas_changed;

   `DLFR_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, empty && !full)
   `DLFR_ASSERT_IMPLY(a_csum_err_last, clock, reset, !empty && (rsp.kind == KIND_CSUM_ERR), rsp.last)
   `DLFR_ASSERT_IMPLY(a_reply_not_last, clock, reset, !empty && (rsp.kind == KIND_REPLY), !rsp.last)
   `DLFR_ASSERT_IMPLY(a_pop_has_job, clock, reset, q_pop, !q_stat.empty)

endmodule
